>>> hdl/cwm_pkg.sv
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types, codes and helpers of the card word machine executor.
// ----------------------------------------------------------------------------
package cwm_pkg;

    // Default geometry
    localparam int MEM_WORDS_DEF   = 100;
    localparam int BLOCK_WORDS_DEF = 10;

    // Fixed field widths
    localparam int CHARS_W   = 32;
    localparam int LEN_W     = 3;
    localparam int OPND_W    = 7;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Character codes used by the decoder
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Input operation codes
    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_START = 3'd1,
        OP_STEP  = 3'd2,
        OP_DATA  = 3'd3,
        OP_END   = 3'd4
    } op_t;

    // Result kinds
    typedef enum logic [2:0] {
        K_STEP = 3'd0,
        K_WORD = 3'd1,
        K_DATA = 3'd2,
        K_HALT = 3'd3,
        K_LOAD = 3'd4,
        K_ERR  = 3'd5
    } kind_t;

    // Machine run mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_WAIT = 2'd2,
        MODE_HALT = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_OPER = 2'd2,
        ST_PD   = 2'd3
    } state_t;

    // One stored word: length above characters
    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [CHARS_W-1:0] chars;
    } mem_word_t;

    // One result item
    typedef struct packed {
        kind_t              kind;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   length;
        logic               last;
        logic [COUNT_W-1:0] counter;
        logic               cmp;
    } result_t;

    // Clip a length to four characters
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        sat_len = (len > 3'd4) ? 3'd4 : len;
    endfunction

    // Zero the characters beyond the length
    function automatic logic [CHARS_W-1:0] mask_chars(input logic [CHARS_W-1:0] c,
                                                      input logic [LEN_W-1:0] len);
        logic [CHARS_W-1:0] m;
        begin
            unique case (len)
                3'd0:    m = 32'h0000_0000;
                3'd1:    m = 32'hFF00_0000;
                3'd2:    m = 32'hFFFF_0000;
                3'd3:    m = 32'hFFFF_FF00;
                default: m = 32'hFFFF_FFFF;
            endcase
            mask_chars = c & m;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

>>> hdl/cwm_word_mem.sv
// ----------------------------------------------------------------------------
// cwm_word_mem
// Word memory with one write port, one registered read port and a valid bit
// per entry; an entry that is not valid reads as an empty word.
// ----------------------------------------------------------------------------
module cwm_word_mem #(
    parameter int MEM_WORDS = cwm_pkg::MEM_WORDS_DEF,
    parameter int AW        = $clog2(MEM_WORDS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  cwm_pkg::mem_word_t  wr_data,
    input  logic                clear,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output cwm_pkg::mem_word_t  rd_data
);

    cwm_pkg::mem_word_t     ram_reg [MEM_WORDS];
    logic [MEM_WORDS-1:0]   valid_reg;
    cwm_pkg::mem_word_t     rd_word_reg;
    logic                   rd_valid_reg;
    logic                   wr_in_range;
    logic                   rd_in_range;

    assign wr_in_range = ({1'b0, wr_addr} < (AW+1)'(MEM_WORDS));
    assign rd_in_range = ({1'b0, rd_addr} < (AW+1)'(MEM_WORDS));

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en && rd_in_range)
        begin
            rd_word_reg <= ram_reg[rd_addr];
        end
    end

    // Track written entries; clear drops all of them at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en && wr_in_range)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

>>> hdl/cwm_out_reg.sv
// ----------------------------------------------------------------------------
// cwm_out_reg
// Output register of the result channel; holds one item until the receiver
// takes it and tells the sequencer when there is room for the next one.
// ----------------------------------------------------------------------------
module cwm_out_reg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  cwm_pkg::result_t                 push_data,
    output logic                             space,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_chars[31:0], out_length[34:32], counter_now[41:35], compare_now[42]
    output logic [cwm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // kind[2:0]
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    logic             valid_reg;
    cwm_pkg::result_t data_reg;

    assign space = !valid_reg || m_axis_tready;

    // Hold the item until taken; load a new one when there is room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && push)
        begin
            data_reg <= push_data;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.last;
    assign m_axis_tdata  = {5'd0, data_reg.cmp, data_reg.counter,
                            data_reg.length, data_reg.chars};

endmodule

>>> hdl/card_word_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// card_word_machine_executor_unit
// Small word machine: program load, start, single step, data cards, end job.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: one command item each; tuser carries the operation,
//   tdata the word characters and length, tlast marks the last data word of
//   a card. Result channel m_axis: tuser carries the result kind, tdata the
//   output word, counter and compare flag, tlast the last word of a block.
// Sequencing:
//   Every item reads the word memory at least once before it completes. Load,
//   start, data, end job and most steps read it once; LR and CR read it twice
//   (instruction read, then operand read); PD reads one memory word per output
//   word. The next item is taken in the cycle after the last result enters the
//   output register.
// Reset:
//   rst_n clears the machine state and the valid bits of the word memory, so
//   every word reads empty; end job clears those bits as well.
// Stall:
//   When m_axis_tready is low the result waits in the output register and
//   the sequencer holds its current item until there is room again.
// ----------------------------------------------------------------------------
module card_word_machine_executor_unit #(
    parameter int MEM_WORDS   = cwm_pkg::MEM_WORDS_DEF,
    parameter int BLOCK_WORDS = cwm_pkg::BLOCK_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // word_chars[31:0], word_length[34:32]
    input  logic [cwm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]                       s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_chars[31:0], out_length[34:32], counter_now[41:35], compare_now[42]
    output logic [cwm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // kind[2:0]
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int AW   = $clog2(MEM_WORDS);
    localparam int CW   = $clog2(MEM_WORDS + 1);
    localparam int CNTW = $clog2(BLOCK_WORDS + 1);
    localparam int OW   = cwm_pkg::OPND_W;

    // Machine state
    cwm_pkg::state_t    state_reg, state_next;
    cwm_pkg::mode_t     mode_reg, mode_next;
    logic [CW-1:0]      lp_reg, lp_next;
    logic [CW-1:0]      pc_reg, pc_next;
    cwm_pkg::mem_word_t gr_reg, gr_next;
    logic               flag_reg, flag_next;
    logic [CW-1:0]      cwp_reg, cwp_next;
    logic [CNTW-1:0]    cwc_reg, cwc_next;

    // Current item and sequencing
    logic [2:0]         op_reg, op_next;
    logic [31:0]        chars_reg, chars_next;
    logic [2:0]         len_reg, len_next;
    logic               last_reg, last_next;
    logic               lr_reg, lr_next;
    logic [CW-1:0]      pd_addr_reg, pd_addr_next;
    logic [CNTW-1:0]    pd_cnt_reg, pd_cnt_next;

    // Memory port
    logic               wr_en, rd_en, mem_clear;
    logic [AW-1:0]      wr_addr, rd_addr;
    cwm_pkg::mem_word_t wr_data, rd_data;

    // Output side
    logic               push, out_space;
    cwm_pkg::result_t   res;

    // Instruction decode
    logic [7:0]         c0, c1, c2, c3;
    logic [OW-1:0]      opnd;
    logic [OW-1:0]      base;
    logic               blk_over;
    logic               opnd_over;
    logic               is_gd, is_pd, is_lsc, is_bt;
    logic [CW:0]        data_addr;
    logic [CW-1:0]      pd_addr_inc;

    // Block base table, one entry per operand value
    logic [OW-1:0]      base_tab [2**OW];

    for (genvar g = 0; g < 2**OW; g++)
    begin : g_base
        assign base_tab[g] = OW'((g / BLOCK_WORDS) * BLOCK_WORDS);
    end

    assign c0 = rd_data.chars[31:24];
    assign c1 = rd_data.chars[23:16];
    assign c2 = rd_data.chars[15:8];
    assign c3 = rd_data.chars[7:0];

    // Operand from character positions three and four
    always_comb
    begin
        logic [3:0] d2;
        logic [3:0] d3;
        d2 = 4'(c2 - cwm_pkg::CH_ZERO);
        d3 = 4'(c3 - cwm_pkg::CH_ZERO);
        if (!cwm_pkg::is_digit(c2))
        begin
            opnd = '0;
        end
        else if (cwm_pkg::is_digit(c3))
        begin
            opnd = OW'({d2, 3'b000}) + OW'({d2, 1'b0}) + OW'(d3);
        end
        else
        begin
            opnd = OW'(d2);
        end
    end

    assign base      = base_tab[opnd];
    assign blk_over  = ({1'b0, base} + (OW+1)'(BLOCK_WORDS)) > (OW+1)'(MEM_WORDS);
    assign opnd_over = (opnd >= OW'(MEM_WORDS));
    assign is_gd     = (c0 == cwm_pkg::CH_G) && (c1 == cwm_pkg::CH_D);
    assign is_pd     = (c0 == cwm_pkg::CH_P) && (c1 == cwm_pkg::CH_D);
    assign is_lsc    = ((c0 == cwm_pkg::CH_L) || (c0 == cwm_pkg::CH_S)
                       || (c0 == cwm_pkg::CH_C)) && (c1 == cwm_pkg::CH_R);
    assign is_bt     = (c0 == cwm_pkg::CH_B) && (c1 == cwm_pkg::CH_T);
    assign data_addr = {1'b0, cwp_reg} + (CW+1)'(cwc_reg);
    assign pd_addr_inc = pd_addr_reg + CW'(1);

    // Sequencer: next state, memory accesses and result item
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        lp_next      = lp_reg;
        pc_next      = pc_reg;
        gr_next      = gr_reg;
        flag_next    = flag_reg;
        cwp_next     = cwp_reg;
        cwc_next     = cwc_reg;
        op_next      = op_reg;
        chars_next   = chars_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        lr_next      = lr_reg;
        pd_addr_next = pd_addr_reg;
        pd_cnt_next  = pd_cnt_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        mem_clear    = 1'b0;
        push         = 1'b0;
        res          = '0;
        res.kind     = cwm_pkg::K_STEP;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            cwm_pkg::ST_IDLE:
            begin
                // Take an item and fetch the instruction word with it
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    chars_next = s_axis_tdata[31:0];
                    len_next   = cwm_pkg::sat_len(s_axis_tdata[34:32]);
                    last_next  = s_axis_tlast;
                    rd_en      = 1'b1;
                    rd_addr    = pc_reg[AW-1:0];
                    state_next = cwm_pkg::ST_EXEC;
                end
            end

            cwm_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    cwm_pkg::OP_LOAD:
                    begin
                        if (out_space)
                        begin
                            push       = 1'b1;
                            state_next = cwm_pkg::ST_IDLE;
                            if (mode_reg != cwm_pkg::MODE_IDLE
                                || (len_reg != 3'd0 && lp_reg >= CW'(MEM_WORDS)))
                            begin
                                res.kind = cwm_pkg::K_ERR;
                            end
                            else
                            begin
                                res.kind = cwm_pkg::K_LOAD;
                                if (len_reg != 3'd0)
                                begin
                                    wr_en          = 1'b1;
                                    wr_addr        = lp_reg[AW-1:0];
                                    wr_data.chars  = cwm_pkg::mask_chars(chars_reg, len_reg);
                                    wr_data.length = len_reg;
                                    lp_next        = lp_reg + CW'(1);
                                end
                            end
                        end
                    end

                    cwm_pkg::OP_START:
                    begin
                        if (out_space)
                        begin
                            push       = 1'b1;
                            state_next = cwm_pkg::ST_IDLE;
                            pc_next    = '0;
                            mode_next  = cwm_pkg::MODE_RUN;
                            cwc_next   = '0;
                        end
                    end

                    cwm_pkg::OP_STEP:
                    begin
                        if (mode_reg != cwm_pkg::MODE_RUN || pc_reg >= CW'(MEM_WORDS))
                        begin
                            if (out_space)
                            begin
                                push       = 1'b1;
                                state_next = cwm_pkg::ST_IDLE;
                                unique case (mode_reg)
                                    cwm_pkg::MODE_WAIT: res.kind = cwm_pkg::K_DATA;
                                    cwm_pkg::MODE_HALT: res.kind = cwm_pkg::K_HALT;
                                    default:            res.kind = cwm_pkg::K_ERR;
                                endcase
                            end
                        end
                        else if (is_gd || is_pd)
                        begin
                            if (blk_over)
                            begin
                                if (out_space)
                                begin
                                    push       = 1'b1;
                                    state_next = cwm_pkg::ST_IDLE;
                                    res.kind   = cwm_pkg::K_ERR;
                                end
                            end
                            else if (is_gd)
                            begin
                                if (out_space)
                                begin
                                    push       = 1'b1;
                                    state_next = cwm_pkg::ST_IDLE;
                                    res.kind   = cwm_pkg::K_DATA;
                                    pc_next    = pc_reg + CW'(1);
                                    mode_next  = cwm_pkg::MODE_WAIT;
                                    cwp_next   = base[CW-1:0];
                                    cwc_next   = '0;
                                end
                            end
                            else
                            begin
                                // Start the block read; words go out in ST_PD
                                pc_next      = pc_reg + CW'(1);
                                pd_addr_next = base[CW-1:0];
                                pd_cnt_next  = '0;
                                rd_en        = 1'b1;
                                rd_addr      = base[AW-1:0];
                                state_next   = cwm_pkg::ST_PD;
                            end
                        end
                        else if (is_lsc)
                        begin
                            if (opnd_over)
                            begin
                                if (out_space)
                                begin
                                    push       = 1'b1;
                                    state_next = cwm_pkg::ST_IDLE;
                                    res.kind   = cwm_pkg::K_ERR;
                                end
                            end
                            else if (c0 == cwm_pkg::CH_S)
                            begin
                                if (out_space)
                                begin
                                    push           = 1'b1;
                                    state_next     = cwm_pkg::ST_IDLE;
                                    wr_en          = 1'b1;
                                    wr_addr        = opnd[AW-1:0];
                                    wr_data.length = cwm_pkg::sat_len(gr_reg.length);
                                    wr_data.chars  = cwm_pkg::mask_chars(gr_reg.chars,
                                                         cwm_pkg::sat_len(gr_reg.length));
                                    pc_next        = pc_reg + CW'(1);
                                end
                            end
                            else
                            begin
                                // Fetch the operand word for LR or CR
                                lr_next    = (c0 == cwm_pkg::CH_L);
                                rd_en      = 1'b1;
                                rd_addr    = opnd[AW-1:0];
                                state_next = cwm_pkg::ST_OPER;
                            end
                        end
                        else if (is_bt)
                        begin
                            if (out_space)
                            begin
                                push       = 1'b1;
                                state_next = cwm_pkg::ST_IDLE;
                                if (!flag_reg)
                                begin
                                    pc_next = pc_reg + CW'(1);
                                end
                                else if (opnd_over)
                                begin
                                    res.kind = cwm_pkg::K_ERR;
                                end
                                else
                                begin
                                    pc_next = opnd[CW-1:0];
                                end
                            end
                        end
                        else if (c0 == cwm_pkg::CH_H)
                        begin
                            if (out_space)
                            begin
                                push       = 1'b1;
                                state_next = cwm_pkg::ST_IDLE;
                                res.kind   = cwm_pkg::K_HALT;
                                mode_next  = cwm_pkg::MODE_HALT;
                            end
                        end
                        else
                        begin
                            // Skip an unknown word
                            if (out_space)
                            begin
                                push       = 1'b1;
                                state_next = cwm_pkg::ST_IDLE;
                                pc_next    = pc_reg + CW'(1);
                            end
                        end
                    end

                    cwm_pkg::OP_DATA:
                    begin
                        if (out_space)
                        begin
                            push       = 1'b1;
                            state_next = cwm_pkg::ST_IDLE;
                            if (mode_reg != cwm_pkg::MODE_WAIT)
                            begin
                                res.kind = cwm_pkg::K_ERR;
                            end
                            else
                            begin
                                if (len_reg != 3'd0 && cwc_reg < CNTW'(BLOCK_WORDS))
                                begin
                                    if (data_addr < (CW+1)'(MEM_WORDS))
                                    begin
                                        wr_en          = 1'b1;
                                        wr_addr        = data_addr[AW-1:0];
                                        wr_data.chars  = cwm_pkg::mask_chars(chars_reg,
                                                                             len_reg);
                                        wr_data.length = len_reg;
                                    end
                                    cwc_next = cwc_reg + CNTW'(1);
                                end
                                if (last_reg)
                                begin
                                    mode_next = cwm_pkg::MODE_RUN;
                                    cwc_next  = '0;
                                end
                            end
                        end
                    end

                    cwm_pkg::OP_END:
                    begin
                        if (out_space)
                        begin
                            push       = 1'b1;
                            state_next = cwm_pkg::ST_IDLE;
                            mem_clear  = 1'b1;
                            lp_next    = '0;
                            mode_next  = cwm_pkg::MODE_IDLE;
                            cwc_next   = '0;
                        end
                    end

                    default:
                    begin
                        if (out_space)
                        begin
                            push       = 1'b1;
                            state_next = cwm_pkg::ST_IDLE;
                            res.kind   = cwm_pkg::K_ERR;
                        end
                    end
                endcase
            end

            cwm_pkg::ST_OPER:
            begin
                // Finish LR or CR with the operand word
                if (out_space)
                begin
                    push       = 1'b1;
                    state_next = cwm_pkg::ST_IDLE;
                    pc_next    = pc_reg + CW'(1);
                    if (lr_reg)
                    begin
                        gr_next = rd_data;
                    end
                    else
                    begin
                        flag_next = (gr_reg == rd_data);
                    end
                end
            end

            cwm_pkg::ST_PD:
            begin
                // Emit one block word per cycle while the output has room, and read the next one
                if (out_space)
                begin
                    push       = 1'b1;
                    res.kind   = cwm_pkg::K_WORD;
                    res.chars  = rd_data.chars;
                    res.length = rd_data.length;
                    res.last   = (pd_cnt_reg == CNTW'(BLOCK_WORDS - 1));
                    if (pd_cnt_reg == CNTW'(BLOCK_WORDS - 1))
                    begin
                        state_next = cwm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pd_addr_next = pd_addr_inc;
                        pd_cnt_next  = pd_cnt_reg + CNTW'(1);
                        rd_en        = 1'b1;
                        rd_addr      = pd_addr_inc[AW-1:0];
                    end
                end
            end

            default:
            begin
                state_next = cwm_pkg::ST_IDLE;
            end
        endcase

        res.counter = cwm_pkg::COUNT_W'(pc_next);
        res.cmp     = flag_next;
    end

    // Control and machine state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cwm_pkg::ST_IDLE;
            mode_reg    <= cwm_pkg::MODE_IDLE;
            lp_reg      <= '0;
            pc_reg      <= '0;
            gr_reg      <= '0;
            flag_reg    <= 1'b0;
            cwp_reg     <= '0;
            cwc_reg     <= '0;
            pd_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            lp_reg      <= lp_next;
            pc_reg      <= pc_next;
            gr_reg      <= gr_next;
            flag_reg    <= flag_next;
            cwp_reg     <= cwp_next;
            cwc_reg     <= cwc_next;
            pd_cnt_reg  <= pd_cnt_next;
        end
    end

    // Item payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        chars_reg   <= chars_next;
        len_reg     <= len_next;
        last_reg    <= last_next;
        lr_reg      <= lr_next;
        pd_addr_reg <= pd_addr_next;
    end

    cwm_word_mem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .clear   (mem_clear),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cwm_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_data     (res),
        .space         (out_space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the card word machine executor. Commands go in with
// random bursts and gaps, results come out under a random ready pattern. Each
// accepted command is run through a behavioral copy of the machine, and every
// result is matched in order against the predicted replies.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WORDS            = cwm_pkg::MEM_WORDS_DEF;
    localparam int BLOCK            = cwm_pkg::BLOCK_WORDS_DEF;
    localparam int RANDOM_ITEMS     = 360;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        cwm_pkg::op_t op;
        logic [31:0]  chars;
        logic [2:0]   len;
        logic         last;
    } command_t;

    typedef struct packed {
        cwm_pkg::kind_t kind;
        logic [31:0]    chars;
        logic [2:0]     len;
        logic           last;
        logic [6:0]     counter;
        logic           cmp;
    } reply_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [cwm_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [2:0]                    s_axis_tuser  = '0;
    logic                          s_axis_tlast  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [cwm_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]                    m_axis_tuser;
    logic                          m_axis_tlast;

    // Machine copy
    logic [31:0]    store_chars [WORDS];
    logic [2:0]     store_len [WORDS];
    int unsigned    next_load;
    int unsigned    pc;
    logic [34:0]    accumulator;
    logic           cmp_flag;
    cwm_pkg::mode_t machine_mode;
    int unsigned    card_base;
    int unsigned    card_fill;

    reply_t   fresh_replies[$];
    reply_t   machine_replies[$];
    command_t command_backlog[$];
    command_t bus_command;

    bit holding     = 1'b0;
    int items_fed   = 0;
    int mismatches  = 0;
    int burst_left  = 4;
    int gap_left    = 0;
    int ready_left  = 0;
    bit ready_phase = 1'b0;

    card_word_machine_executor_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Behavioral machine
    // ------------------------------------------------------------------
    function automatic logic [2:0] clip_len(input logic [2:0] n);
        return (n > 3'd4) ? 3'd4 : n;
    endfunction

    // Zero the characters past the length
    function automatic logic [31:0] trim_chars(input logic [31:0] c, input logic [2:0] n);
        return (n >= 3'd4) ? c : (c & ~(32'hFFFF_FFFF >> (8 * n)));
    endfunction

    function automatic bit numeral(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic void post_reply(input cwm_pkg::kind_t k, input logic [31:0] c,
                                       input logic [2:0] n, input logic last);
        reply_t r;
        r = '0;
        r.kind  = k;
        r.chars = c;
        r.len   = n;
        r.last  = last;
        fresh_replies.push_back(r);
    endfunction

    function automatic void clear_store();
        int a;
        for (a = 0; a < WORDS; a++)
        begin
            store_chars[a] = '0;
            store_len[a]   = '0;
        end
    endfunction

    function automatic void put_word(input int unsigned a, input logic [31:0] c,
                                     input logic [2:0] n);
        store_chars[a] = trim_chars(c, n);
        store_len[a]   = n;
    endfunction

    // Run the instruction at the counter
    function automatic void execute_instruction();
        logic [31:0] w;
        logic [7:0]  c0, c1, c2, c3;
        int unsigned opnd;
        int unsigned base;
        int          j;
        if (machine_mode == cwm_pkg::MODE_IDLE)
            post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
        else if (machine_mode == cwm_pkg::MODE_WAIT)
            post_reply(cwm_pkg::K_DATA, '0, '0, 1'b0);
        else if (machine_mode == cwm_pkg::MODE_HALT)
            post_reply(cwm_pkg::K_HALT, '0, '0, 1'b0);
        else if (pc >= WORDS)
            post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
        else
        begin
            w  = store_chars[pc];
            c0 = w[31:24];
            c1 = w[23:16];
            c2 = w[15:8];
            c3 = w[7:0];
            opnd = 0;
            if (numeral(c2))
            begin
                opnd = c2 - "0";
                if (numeral(c3))
                    opnd = opnd * 10 + (c3 - "0");
            end
            base = opnd - (opnd % BLOCK);

            if ((c0 == "G" || c0 == "P") && c1 == "D")
            begin
                if (base + BLOCK > WORDS)
                    post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
                else
                begin
                    pc++;
                    if (c0 == "G")
                    begin
                        machine_mode = cwm_pkg::MODE_WAIT;
                        card_base    = base;
                        card_fill    = 0;
                        post_reply(cwm_pkg::K_DATA, '0, '0, 1'b0);
                    end
                    else
                    begin
                        for (j = 0; j < BLOCK; j++)
                            post_reply(cwm_pkg::K_WORD, store_chars[base + j],
                                       store_len[base + j], j == BLOCK - 1);
                    end
                end
            end
            else if ((c0 == "L" || c0 == "S" || c0 == "C") && c1 == "R")
            begin
                if (opnd >= WORDS)
                    post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
                else
                begin
                    if (c0 == "L")
                        accumulator = {store_len[opnd], store_chars[opnd]};
                    else if (c0 == "S")
                        put_word(opnd, accumulator[31:0], clip_len(accumulator[34:32]));
                    else
                        cmp_flag = (accumulator == {store_len[opnd], store_chars[opnd]});
                    pc++;
                    post_reply(cwm_pkg::K_STEP, '0, '0, 1'b0);
                end
            end
            else if (c0 == "B" && c1 == "T")
            begin
                if (cmp_flag && opnd >= WORDS)
                    post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
                else
                begin
                    pc = cmp_flag ? opnd : pc + 1;
                    post_reply(cwm_pkg::K_STEP, '0, '0, 1'b0);
                end
            end
            else if (c0 == "H")
            begin
                machine_mode = cwm_pkg::MODE_HALT;
                post_reply(cwm_pkg::K_HALT, '0, '0, 1'b0);
            end
            else
            begin
                // Unknown word: skip it
                pc++;
                post_reply(cwm_pkg::K_STEP, '0, '0, 1'b0);
            end
        end
    endfunction

    // Apply one accepted command and queue its replies
    function automatic void execute_command(input command_t cmd);
        logic [2:0] n;
        reply_t     r;
        int         i;
        n = clip_len(cmd.len);
        fresh_replies.delete();
        case (cmd.op)
            cwm_pkg::OP_LOAD:
            begin
                if (machine_mode != cwm_pkg::MODE_IDLE || (n != 0 && next_load >= WORDS))
                    post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
                else
                begin
                    if (n != 0)
                    begin
                        put_word(next_load, cmd.chars, n);
                        next_load++;
                    end
                    post_reply(cwm_pkg::K_LOAD, '0, '0, 1'b0);
                end
            end
            cwm_pkg::OP_START:
            begin
                pc           = 0;
                machine_mode = cwm_pkg::MODE_RUN;
                card_fill    = 0;
                post_reply(cwm_pkg::K_STEP, '0, '0, 1'b0);
            end
            cwm_pkg::OP_STEP:
                execute_instruction();
            cwm_pkg::OP_DATA:
            begin
                if (machine_mode != cwm_pkg::MODE_WAIT)
                    post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
                else
                begin
                    // Drop words past the block size
                    if (n != 0 && card_fill < BLOCK)
                    begin
                        if (card_base + card_fill < WORDS)
                            put_word(card_base + card_fill, cmd.chars, n);
                        card_fill++;
                    end
                    if (cmd.last)
                    begin
                        machine_mode = cwm_pkg::MODE_RUN;
                        card_fill    = 0;
                    end
                    post_reply(cwm_pkg::K_STEP, '0, '0, 1'b0);
                end
            end
            cwm_pkg::OP_END:
            begin
                clear_store();
                next_load    = 0;
                machine_mode = cwm_pkg::MODE_IDLE;
                card_fill    = 0;
                post_reply(cwm_pkg::K_STEP, '0, '0, 1'b0);
            end
            default:
                post_reply(cwm_pkg::K_ERR, '0, '0, 1'b0);
        endcase
        for (i = 0; i < fresh_replies.size(); i++)
        begin
            r         = fresh_replies[i];
            r.counter = 7'(pc);
            r.cmp     = cmp_flag;
            machine_replies.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic feed(input cwm_pkg::op_t op, input logic [31:0] chars,
                        input logic [2:0] len, input logic last);
        command_t c;
        c.op    = op;
        c.chars = chars;
        c.len   = len;
        c.last  = last;
        command_backlog.push_back(c);
        items_fed++;
    endtask

    // Wait until every queued command has been taken and predicted
    task automatic settle();
        while (command_backlog.size() != 0 || holding)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 7))
            0: return "G";
            1: return "P";
            2: return "L";
            3: return "S";
            4: return "C";
            5: return "B";
            6: return "D";
            default: return "R";
        endcase
    endfunction

    function automatic logic [7:0] non_digit();
        return ($urandom_range(0, 1) != 0) ? 8'h2F : 8'h3A;
    endfunction

    // Build an instruction word; returns length above characters
    function automatic logic [34:0] instruction_word(input logic [7:0] a, input logic [7:0] b,
                                                     input int opnd);
        logic [7:0] tens, ones;
        int         form;
        tens = 8'("0" + opnd / 10);
        ones = 8'("0" + opnd % 10);
        form = $urandom_range(0, 19);
        if (form < 14)
            return {3'd4, a, b, tens, ones};
        else if (form < 16)
            return {3'd4, a, b, ones, non_digit()};
        else if (form < 18)
            return {3'd4, a, b, non_digit(), ones};
        else
            return {3'd3, a, b, tens, ones};
    endfunction

    task automatic load_program();
        int          n, i, pick, opnd;
        logic [7:0]  a, b;
        logic [34:0] w;
        n = $urandom_range(3, 14);
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (i == n - 1 && $urandom_range(0, 3) != 0)
                pick = 99;
            if (pick < 36)
            begin
                a = (pick < 18) ? "G" : "P";
                b = "D";
                opnd = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 19)
                                                   : $urandom_range(20, 99);
                w = instruction_word(a, b, opnd);
            end
            else if (pick < 66)
            begin
                a = (pick < 46) ? "L" : (pick < 56) ? "S" : "C";
                opnd = ($urandom_range(0, 1) != 0) ? $urandom_range(20, 49)
                                                   : $urandom_range(0, 99);
                w = instruction_word(a, "R", opnd);
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 4))
                    0: opnd = $urandom_range(98, 99);
                    1: opnd = $urandom_range(0, 99);
                    default: opnd = $urandom_range(0, n - 1);
                endcase
                w = instruction_word("B", "T", opnd);
            end
            else if (pick < 86)
                w = instruction_word(pick_letter(), pick_letter(), $urandom_range(0, 99));
            else if (pick < 89)
                w = {3'($urandom_range(1, 4)), 32'($urandom)};
            else if (pick < 92)
                w = {3'd0, 32'($urandom)};
            else
                w = {3'($urandom_range(1, 4)), "H", 24'($urandom)};
            feed(cwm_pkg::OP_LOAD, w[31:0], w[34:32], 1'($urandom));
        end
    endtask

    // Answer a machine that waits for a card
    task automatic feed_card();
        int words, w, sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            feed(cwm_pkg::OP_END, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
        else if (sel == 1)
            feed(cwm_pkg::OP_START, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
        else
        begin
            if (sel == 2)
                feed(cwm_pkg::OP_STEP, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
            words = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 13) : $urandom_range(1, 10);
            for (w = 0; w < words; w++)
                feed(cwm_pkg::OP_DATA, $urandom,
                     ($urandom_range(0, 6) == 0) ? 3'd0 : 3'($urandom_range(1, 4)),
                     w == words - 1);
        end
    endtask

    // Out-of-place commands while running
    task automatic feed_noise();
        case ($urandom_range(0, 3))
            0: feed(cwm_pkg::OP_LOAD, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
            1: feed(cwm_pkg::OP_DATA, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
            2: feed(cwm_pkg::OP_START, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
            default: feed(cwm_pkg::OP_END, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
        endcase
    endtask

    // One job: clear, load, start, then step and serve cards
    task automatic run_job(input bit fill_memory);
        int k, chunks;
        bit open;
        feed(cwm_pkg::OP_END, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
        if (fill_memory)
        begin
            // One load more than memory holds
            for (k = 0; k <= WORDS; k++)
                feed(cwm_pkg::OP_LOAD, $urandom, 3'($urandom_range(1, 4)), 1'($urandom));
        end
        else
            load_program();
        feed(cwm_pkg::OP_START, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
        open   = 1'b1;
        chunks = 0;
        while (open && chunks < 30)
        begin
            settle();
            chunks++;
            case (machine_mode)
                cwm_pkg::MODE_WAIT:
                    feed_card();
                cwm_pkg::MODE_RUN:
                begin
                    if (pc >= WORDS)
                    begin
                        feed(cwm_pkg::OP_STEP, $urandom, 3'($urandom_range(0, 4)),
                             1'($urandom));
                        open = 1'b0;
                    end
                    else if ($urandom_range(0, 11) == 0)
                        feed_noise();
                    else
                        repeat ($urandom_range(1, 4))
                            feed(cwm_pkg::OP_STEP, $urandom, 3'($urandom_range(0, 4)),
                                 1'($urandom));
                end
                cwm_pkg::MODE_HALT:
                begin
                    feed(cwm_pkg::OP_STEP, $urandom, 3'($urandom_range(0, 4)), 1'($urandom));
                    if ($urandom_range(0, 2) == 0)
                        feed(cwm_pkg::OP_START, $urandom, 3'($urandom_range(0, 4)),
                             1'($urandom));
                    else
                        open = 1'b0;
                end
                default:
                    open = 1'b0;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Command driver: bursts of items with random gaps
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !holding)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (command_backlog.size() != 0)
            begin
                bus_command = command_backlog.pop_front();
                s_axis_tdata  <= {5'b0, bus_command.len, bus_command.chars};
                s_axis_tuser  <= bus_command.op;
                s_axis_tlast  <= bus_command.last;
                s_axis_tvalid <= 1'b1;
                holding = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left--;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result ready: alternating runs, now and then a long open stretch
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_phase = !ready_phase;
            if (ready_phase)
                ready_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
            else
                ready_left = $urandom_range(1, 6);
        end
        ready_left--;
        m_axis_tready <= ready_phase;
    end

    // ------------------------------------------------------------------
    // Monitor: predict accepted commands, check results in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_bus
        reply_t want, got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                execute_command(bus_command);
                holding = 1'b0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind    = cwm_pkg::kind_t'(m_axis_tuser);
                got.chars   = m_axis_tdata[31:0];
                got.len     = m_axis_tdata[34:32];
                got.last    = m_axis_tlast;
                got.counter = m_axis_tdata[41:35];
                got.cmp     = m_axis_tdata[42];
                if (machine_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("unexpected result item: kind %0d chars %h", m_axis_tuser,
                                 m_axis_tdata[31:0]);
                end
                else
                begin
                    want = machine_replies.pop_front();
                    if (got.kind !== want.kind || got.chars !== want.chars ||
                        got.len !== want.len || got.last !== want.last ||
                        got.counter !== want.counter || got.cmp !== want.cmp)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN_MISMATCHES)
                        begin
                            $display("mismatch (exp/got): kind %0d/%0d chars %h/%h len %0d/%0d",
                                     want.kind, m_axis_tuser, want.chars, got.chars,
                                     want.len, got.len);
                            $display("    last %0d/%0d counter %0d/%0d cmp %0d/%0d",
                                     want.last, got.last, want.counter, got.counter,
                                     want.cmp, got.cmp);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        int job;
        clear_store();
        next_load    = 0;
        pc           = 0;
        accumulator  = '0;
        cmp_flag     = 1'b0;
        machine_mode = cwm_pkg::MODE_IDLE;
        card_base    = 0;
        card_fill    = 0;
        wait (rst_n);

        // Commands out of place right after reset
        feed(cwm_pkg::OP_STEP, $urandom, 3'd4, 1'b0);
        feed(cwm_pkg::OP_DATA, 32'hFFFF_FFFF, 3'd4, 1'b1);

        // Compare hit, taken branch near the top, run off the end of memory
        feed(cwm_pkg::OP_LOAD, "CR50", 3'd4, 1'b0);
        feed(cwm_pkg::OP_LOAD, 32'hFFFF_FFFF, 3'd0, 1'b1);
        feed(cwm_pkg::OP_LOAD, "BT98", 3'd4, 1'b0);
        feed(cwm_pkg::OP_START, 32'h0, 3'd0, 1'b0);
        repeat (5) feed(cwm_pkg::OP_STEP, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_START, 32'hFFFF_FFFF, 3'd4, 1'b1);

        // Card read, block print and halt
        feed(cwm_pkg::OP_END, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_LOAD, "GD20", 3'd4, 1'b0);
        feed(cwm_pkg::OP_LOAD, "PD20", 3'd4, 1'b0);
        feed(cwm_pkg::OP_LOAD, {"H", 24'hFFFFFF}, 3'd1, 1'b0);
        feed(cwm_pkg::OP_START, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_STEP, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_STEP, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_LOAD, "LR20", 3'd4, 1'b0);
        feed(cwm_pkg::OP_DATA, 32'hFFFF_FFFF, 3'd4, 1'b0);
        feed(cwm_pkg::OP_DATA, 32'h1234_5678, 3'd0, 1'b0);
        feed(cwm_pkg::OP_DATA, "ABCD", 3'd2, 1'b1);
        feed(cwm_pkg::OP_STEP, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_STEP, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_STEP, 32'h0, 3'd0, 1'b0);
        feed(cwm_pkg::OP_DATA, 32'h0, 3'd1, 1'b1);
        feed(cwm_pkg::OP_END, 32'hFFFF_FFFF, 3'd4, 1'b1);

        // Random jobs; the third one fills memory to the brim
        items_fed = 0;
        job = 0;
        while (items_fed < RANDOM_ITEMS)
        begin
            run_job(job == 2);
            job++;
        end

        // Drain
        settle();
        while (machine_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && machine_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
